>>> hw/rtl/hhbs_pkg.sv
package hhbs_pkg;

	// Part capacity in bytes
	localparam int unsigned MAX_LEN = 4096;
	localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);

	// Port widths fixed by the result format
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned POS_W  = 12;
	localparam int unsigned LEN_W  = 13;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	// Parse phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_HDR_LINE = 3'd1,
		PH_HDR_LF   = 3'd2,
		PH_GAP      = 3'd3,
		PH_BODY     = 3'd4
	} phase_t;

	// Result of one parse step
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  hdr_len;
		logic [LEN_W-1:0]  body_len;
		logic              ovf;
	} result_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

>>> hw/rtl/http_header_body_splitter_core.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   msg_byte
// out       out_valid / out_stall item_kind, out_byte, position, header_length,
//                                 body_length, overflow
//
// One byte per cycle sustained while the output is not stalled.
// The byte is held in an input register, parsed, and the result registered.
// Reset clears the parse phase, counters, overflow flag and both valid bits.
// in_stall rises only when the input register is full and the output
// register is full and stalled; dropped bytes still take their slot.
module http_header_body_splitter_core
	import hhbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] msg_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] item_kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic [POS_W-1:0]  position,
	output logic [LEN_W-1:0]  header_length,
	output logic [LEN_W-1:0]  body_length,
	output logic              overflow
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res;
	logic              out_free;
	logic              adv;
	logic              in_acc;

	// Flow control
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_acc   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= msg_byte;
		end
	end

	hhbs_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.data   (byte_s1),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign item_kind     = out_q.kind;
	assign out_byte      = out_q.data;
	assign position      = out_q.pos;
	assign header_length = out_q.hdr_len;
	assign body_length   = out_q.body_len;
	assign overflow      = out_q.ovf;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with nothing held");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == KIND_END |-> out_q.data == '0 && out_q.pos == '0)
		else $error("end item carries byte fields");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != KIND_END |->
			out_q.hdr_len == '0 && out_q.body_len == '0
			&& (out_q.kind == KIND_HEADER || out_q.kind == KIND_BODY))
		else $error("byte item carries lengths or bad kind");

endmodule

>>> hw/rtl/hhbs_parser.sv
module hhbs_parser
	import hhbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data,
	output result_t           res
);

	phase_t           phase_q, phase_nxt;
	logic [CNT_W-1:0] hdr_cnt_q, body_cnt_q;
	logic [CNT_W-1:0] hdr_trim_q, body_trim_q;
	logic             ovf_q;

	logic             is_end;
	logic             want_emit;
	kind_t            part;
	logic [CNT_W-1:0] part_cnt;
	logic             part_full;
	logic             emit;

	assign is_end = (data == CH_NUL);

	// Next phase
	always_comb begin
		phase_nxt = phase_q;
		if (is_end) begin
			phase_nxt = PH_IDLE;
		end else if (data == CH_SP || data == CH_TAB) begin
			phase_nxt = phase_q;
		end else if (data == CH_LF) begin
			case (phase_q)
				PH_HDR_LINE: phase_nxt = PH_HDR_LF;
				PH_HDR_LF:   phase_nxt = PH_GAP;
				default:     phase_nxt = phase_q;
			endcase
		end else if (phase_q == PH_GAP || phase_q == PH_BODY) begin
			phase_nxt = PH_BODY;
		end else begin
			phase_nxt = PH_HDR_LINE;
		end
	end

	// Emit decision and target part
	always_comb begin
		want_emit = 1'b0;
		part      = KIND_HEADER;
		if (is_end) begin
			want_emit = 1'b0;
		end else if (data == CH_SP || data == CH_TAB || data == CH_LF) begin
			case (phase_q)
				PH_HDR_LINE: begin
					want_emit = 1'b1;
					part      = KIND_HEADER;
				end
				PH_BODY: begin
					want_emit = 1'b1;
					part      = KIND_BODY;
				end
				default: want_emit = 1'b0;
			endcase
		end else if (phase_q == PH_GAP || phase_q == PH_BODY) begin
			want_emit = 1'b1;
			part      = KIND_BODY;
		end else begin
			want_emit = 1'b1;
			part      = KIND_HEADER;
		end
	end

	assign part_cnt  = (part == KIND_BODY) ? body_cnt_q : hdr_cnt_q;
	assign part_full = (part_cnt >= CNT_W'(MAX_LEN));
	assign emit      = want_emit && !part_full;

	// Result fields
	always_comb begin
		res          = '0;
		res.valid    = is_end || emit;
		res.ovf      = ovf_q;
		if (is_end) begin
			res.kind     = KIND_END;
			res.hdr_len  = LEN_W'(hdr_trim_q);
			res.body_len = LEN_W'(body_trim_q);
		end else begin
			res.kind = part;
			res.data = data;
			res.pos  = POS_W'(part_cnt);
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_cnt_q   <= '0;
			body_cnt_q  <= '0;
			hdr_trim_q  <= '0;
			body_trim_q <= '0;
			ovf_q       <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nxt;
			if (is_end) begin
				hdr_cnt_q   <= '0;
				body_cnt_q  <= '0;
				hdr_trim_q  <= '0;
				body_trim_q <= '0;
				ovf_q       <= 1'b0;
			end else if (emit) begin
				if (part == KIND_BODY) begin
					body_cnt_q <= body_cnt_q + 1'b1;
					if (!is_blank(data)) begin
						body_trim_q <= body_cnt_q + 1'b1;
					end
				end else begin
					hdr_cnt_q <= hdr_cnt_q + 1'b1;
					if (!is_blank(data)) begin
						hdr_trim_q <= hdr_cnt_q + 1'b1;
					end
				end
			end else if (want_emit) begin
				ovf_q <= 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= CNT_W'(MAX_LEN) && body_cnt_q <= CNT_W'(MAX_LEN))
		else $error("part count beyond capacity");

	a_trim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_trim_q <= hdr_cnt_q && body_trim_q <= body_cnt_q)
		else $error("trimmed length beyond part count");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_end |=> phase_q == PH_IDLE && hdr_cnt_q == '0 && body_cnt_q == '0
			&& !ovf_q)
		else $error("state not cleared after end item");

endmodule
